FILE: rtl/mpq_pkg.sv
// Package for the max priority queue: capacity, widths, status codes and
// the command word that is broadcast to every storage cell. No dependencies.
package mpq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } mpq_cmd_t;

endpackage

FILE: rtl/mpq_cell.sv
// One storage cell of the sorted queue row. It holds one word and its valid
// bit and trades words with its neighbors. Depends on mpq_pkg.
module mpq_cell
  import mpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mpq_cmd_t                 cmd,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic                     left_vld,
  input  logic                     left_ge,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic                     right_vld,
  output logic signed [DATA_W-1:0] data,
  output logic                     vld,
  output logic                     ge
);

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic                     vld_r, vld_nxt;

  assign ge   = vld_r && ($signed(data_r) >= $signed(cmd.value));
  assign data = data_r;
  assign vld  = vld_r;

  always_comb begin
    data_nxt = data_r;
    vld_nxt  = vld_r;
    if (cmd.ins && !ge) begin
      if (left_ge) begin
        data_nxt = cmd.value;
        vld_nxt  = 1'b1;
      end else begin
        data_nxt = left_data;
        vld_nxt  = left_vld;
      end
    end else if (cmd.rem) begin
      data_nxt = right_data;
      vld_nxt  = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

FILE: rtl/max_priority_queue_top.sv
// Top level of the max priority queue: a row of sorted storage cells, the
// occupancy counter and the result register. Depends on mpq_pkg and mpq_cell.
//
// The queue keeps up to CAPACITY signed words in a row of cells sorted from
// highest at the head to lowest at the tail, with equal words in arrival
// order. An insert compares the new word against every cell at once and the
// cells below the insertion point shift one place toward the tail; a remove
// takes the head and every cell shifts one place toward the head. A new
// request is taken in every cycle while the result register is free or
// being read, and its result word appears in the cycle after acceptance.
// Reset empties the queue at once.
module max_priority_queue_top
  import mpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic signed [DATA_W-1:0] in_data_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [STAT_W-1:0]        out_status,
  output logic [OCC_W-1:0]         out_occupancy
);

  mpq_cmd_t                 cmd;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_vld;
  logic [CAPACITY-1:0]      cell_ge;
  logic                     in_acc;
  logic                     full;
  logic                     empty;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] data_out_r, data_out_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic [OCC_W-1:0]         occ_r, occ_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign full     = cell_vld[CAPACITY-1];
  assign empty    = !cell_vld[0];

  assign cmd.ins   = in_acc && !in_req_type && !full;
  assign cmd.rem   = in_acc && in_req_type && !empty;
  assign cmd.value = in_data_in;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] l_data, r_data;
    logic                     l_vld, l_ge, r_vld;

    if (i == 0) begin : g_head
      assign l_data = '0;
      assign l_vld  = 1'b1;
      assign l_ge   = 1'b1;
    end else begin : g_mid
      assign l_data = cell_data[i-1];
      assign l_vld  = cell_vld[i-1];
      assign l_ge   = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_data = '0;
      assign r_vld  = 1'b0;
    end else begin : g_body
      assign r_data = cell_data[i+1];
      assign r_vld  = cell_vld[i+1];
    end

    mpq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_data  (l_data),
      .left_vld   (l_vld),
      .left_ge    (l_ge),
      .right_data (r_data),
      .right_vld  (r_vld),
      .data       (cell_data[i]),
      .vld        (cell_vld[i]),
      .ge         (cell_ge[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    data_out_nxt  = data_out_r;
    status_nxt    = status_r;
    occ_nxt       = occ_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      data_out_nxt  = cmd.rem ? cell_data[0] : '0;
      if (!in_req_type && full) begin
        status_nxt = ST_FULL;
      end else if (in_req_type && empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_OK;
      end
      occ_nxt = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_out_r <= data_out_nxt;
    status_r   <= status_nxt;
    occ_r      <= occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data_out  = data_out_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

  // The valid cells always form an unbroken run from the head, and the stored
  // words never rise from head toward tail.
  logic vld_prefix_ok;
  logic sorted_ok;

  always_comb begin
    vld_prefix_ok = 1'b1;
    sorted_ok     = 1'b1;
    for (int k = 1; k < CAPACITY; k++) begin
      if (cell_vld[k] && !cell_vld[k-1]) begin
        vld_prefix_ok = 1'b0;
      end
      if (cell_vld[k] && ($signed(cell_data[k]) > $signed(cell_data[k-1]))) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_vld_prefix : assert property (@(posedge clk) disable iff (!rst_n) vld_prefix_ok)
    else $error("valid cells do not form a run from the head");

  a_sorted : assert property (@(posedge clk) disable iff (!rst_n) sorted_ok)
    else $error("cell row is not sorted");

  a_count : assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'($countones(cell_vld)) == count_r)
    else $error("occupancy counter disagrees with the valid cells");

  a_remove_head : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type && cell_vld[0]) |=>
      (out_valid && out_data_out == $past(cell_data[0]) && out_status == ST_OK))
    else $error("remove did not return the head word");

  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL || out_status == ST_EMPTY))
    else $error("undefined status code");

endmodule

FILE: tb/sv/max_priority_queue_top_tb.sv
// Self-checking testbench for max_priority_queue_top: directed and random insert and remove
// words, randomly gapped on the input and stalled on the output, checked against a predictor.
// Depends on mpq_pkg and the max_priority_queue_top RTL.
module max_priority_queue_top_tb
  import mpq_pkg::*;
;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;
  localparam int RANDOM_WORDS = 1900;
  localparam int DRAIN_EVERY = 500;
  localparam int LONG_HOLD = 150;
  localparam int HOLD_SPACING = 900;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE} rx_mode_t;

  typedef struct {
    logic                     req;
    logic signed [DATA_W-1:0] value;
    bit                       drain;
  } request_t;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occ;
  } pq_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_req_type = 1'b0;
  logic signed [DATA_W-1:0] in_data_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_data_out;
  logic [STAT_W-1:0]        out_status;
  logic [OCC_W-1:0]         out_occupancy;

  request_t                 pending_q[$];
  pq_result_t               expected_q[$];
  logic signed [DATA_W-1:0] held_values[$];

  int in_issued = 0;
  int in_taken = 0;
  int out_got = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int total_words = 0;
  int n_insert = 0;
  int n_remove = 0;
  int n_full = 0;
  int n_empty = 0;

  int gap_left = 0;
  int burst_left = 1;
  int hold_left = 0;
  int next_hold_at = 300;
  int mode_left = 0;
  rx_mode_t ready_mode = RX_ALWAYS;

  max_priority_queue_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .out_occupancy(out_occupancy)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic pq_result_t serve_request(input logic req,
                                               input logic signed [DATA_W-1:0] value);
    pq_result_t r;
    int top;
    r.data = '0;
    r.status = ST_OK;
    if (req == REQ_INSERT) begin
      n_insert++;
      if (held_values.size() >= CAPACITY) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        held_values.push_back(value);
      end
    end else begin
      n_remove++;
      if (held_values.size() == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        top = 0;
        for (int i = 1; i < held_values.size(); i++) begin
          if (held_values[i] > held_values[top]) top = i;
        end
        r.data = held_values[top];
        held_values.delete(top);
      end
    end
    r.occ = OCC_W'(held_values.size());
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFFFFFF;
          1: v = 32'h80000000;
          2: v = 0;
          default: v = -1;
        endcase
      end
      1, 2: v = int'($urandom_range(0, 8)) - 4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic void add_request(input logic req, input logic signed [DATA_W-1:0] value);
    request_t r;
    r.req = req;
    r.value = value;
    r.drain = (pending_q.size() > 0) && (pending_q.size() % DRAIN_EVERY == 0);
    pending_q.push_back(r);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken == in_issued) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_q[0].drain && (in_taken != in_issued || expected_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_req_type <= pending_q[0].req;
        in_data_in <= pending_q[0].value;
        void'(pending_q.pop_front());
        in_issued++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left == 0 && out_got >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at += HOLD_SPACING;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 100);
        ready_mode = rx_mode_t'($urandom_range(0, 2));
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (ready_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    pq_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_got++;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: data_out %0d, status %0d, occupancy %0d",
                 out_data_out, out_status, out_occupancy);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_out !== want.data) begin
            $error("data_out mismatch: expected %0d, got %0d", want.data, out_data_out);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_occupancy !== want.occ) begin
            $error("occupancy mismatch: expected %0d, got %0d", want.occ, out_occupancy);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(serve_request(in_req_type, in_data_in));
        in_taken++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog expired after %0d idle cycles", idle_cycles);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int seg_len;
    int ins_pct;
    int made;
    add_request(REQ_REMOVE, 32'hFFFFFFFF);
    add_request(REQ_INSERT, 32'h7FFFFFFF);
    add_request(REQ_INSERT, 32'h80000000);
    add_request(REQ_INSERT, 32'h00000000);
    add_request(REQ_INSERT, 32'hFFFFFFFF);
    add_request(REQ_INSERT, 32'sd1);
    add_request(REQ_INSERT, 32'h80000000);
    add_request(REQ_INSERT, 32'h7FFFFFFF);
    add_request(REQ_INSERT, 32'sd2);
    add_request(REQ_INSERT, -32'sd2);
    add_request(REQ_INSERT, 32'h55555555);
    add_request(REQ_INSERT, 32'hAAAAAAAA);
    add_request(REQ_INSERT, 32'sd3);
    add_request(REQ_INSERT, -32'sd3);
    add_request(REQ_INSERT, 32'sd4);
    add_request(REQ_INSERT, -32'sd4);
    add_request(REQ_INSERT, 32'sd5);
    add_request(REQ_INSERT, 32'sd6);
    repeat (6) add_request(REQ_REMOVE, 32'hFFFFFFFF);

    made = 0;
    while (made < RANDOM_WORDS) begin
      seg_len = $urandom_range(10, 80);
      case ($urandom_range(0, 2))
        0: ins_pct = 80;
        1: ins_pct = 50;
        default: ins_pct = 25;
      endcase
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < ins_pct) add_request(REQ_INSERT, pick_value());
        else add_request(REQ_REMOVE, $urandom);
        made++;
      end
    end
    total_words = pending_q.size();

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    while (!(in_taken == total_words && expected_q.size() == 0)) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d words: %0d inserts (%0d refused as full), %0d removes (%0d on empty).",
             in_taken, n_insert, n_full, n_remove, n_empty);
    $display("Checked %0d result words with %0d mismatches.", out_got, fail_count);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
